// ===== rtl/core/vfce_pkg.sv =====
// Package for the voxel face culling vertex emitter: types, codes and corner tables.
`default_nettype none
package vfce_pkg;

  localparam int NUM_FACES    = 6;
  localparam int FACE_BITS    = 3;
  localparam int TEX_BITS     = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int VERT_BITS    = 3;

  typedef logic [TEX_BITS-1:0]  tex_t;
  typedef tex_t [NUM_FACES-1:0] tex_bank_t;
  typedef logic [NUM_FACES-1:0] face_mask_t;
  typedef logic [FACE_BITS-1:0] face_t;

  localparam face_t FACE_PX = 3'd0;
  localparam face_t FACE_NX = 3'd1;
  localparam face_t FACE_PY = 3'd2;
  localparam face_t FACE_NY = 3'd3;
  localparam face_t FACE_PZ = 3'd4;
  localparam face_t FACE_NZ = 3'd5;

  localparam logic [1:0] CORNER_BL = 2'd0;
  localparam logic [1:0] CORNER_TL = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_TR = 2'd3;

  localparam logic [VERT_BITS-1:0] LAST_VERT = 3'd5;

  // corner order within a face: BL, TL, BR, BR, TL, TR
  function automatic logic [1:0] emit_corner(input logic [VERT_BITS-1:0] k);
    logic [1:0] c;
    unique case (k)
      3'd0:    c = CORNER_BL;
      3'd1:    c = CORNER_TL;
      3'd2:    c = CORNER_BR;
      3'd3:    c = CORNER_BR;
      3'd4:    c = CORNER_TL;
      3'd5:    c = CORNER_TR;
      default: c = CORNER_BL;
    endcase
    return c;
  endfunction

  // offset bits {x, y, z} of a corner of a face
  function automatic logic [2:0] corner_offset(input face_t f, input logic [1:0] c);
    logic [2:0] o;
    unique case (f)
      FACE_PX: begin
        unique case (c)
          CORNER_BL: o = 3'b101;
          CORNER_TL: o = 3'b111;
          CORNER_BR: o = 3'b100;
          default:   o = 3'b110;
        endcase
      end
      FACE_NX: begin
        unique case (c)
          CORNER_BL: o = 3'b000;
          CORNER_TL: o = 3'b010;
          CORNER_BR: o = 3'b001;
          default:   o = 3'b011;
        endcase
      end
      FACE_PY: begin
        unique case (c)
          CORNER_BL: o = 3'b010;
          CORNER_TL: o = 3'b110;
          CORNER_BR: o = 3'b011;
          default:   o = 3'b111;
        endcase
      end
      FACE_NY: begin
        unique case (c)
          CORNER_BL: o = 3'b100;
          CORNER_TL: o = 3'b000;
          CORNER_BR: o = 3'b101;
          default:   o = 3'b001;
        endcase
      end
      FACE_PZ: begin
        unique case (c)
          CORNER_BL: o = 3'b001;
          CORNER_TL: o = 3'b011;
          CORNER_BR: o = 3'b101;
          default:   o = 3'b111;
        endcase
      end
      FACE_NZ: begin
        unique case (c)
          CORNER_BL: o = 3'b100;
          CORNER_TL: o = 3'b110;
          CORNER_BR: o = 3'b000;
          default:   o = 3'b010;
        endcase
      end
      default: o = 3'b000;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/vfce_front.sv =====
// Front stage: registers incoming cube requests and drops cubes with no visible face.
`default_nettype none
module vfce_front #(
  parameter int COORD_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [COORD_BITS-1:0]         in_pos_x,
  input  wire logic [COORD_BITS-1:0]         in_pos_y,
  input  wire logic [COORD_BITS-1:0]         in_pos_z,
  input  wire vfce_pkg::face_mask_t          in_mask,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output logic [3*COORD_BITS+vfce_pkg::NUM_FACES-1:0] push_data
);
  import vfce_pkg::*;

  logic                  valid_r, valid_nxt;
  logic [COORD_BITS-1:0] x_r, y_r, z_r;
  face_mask_t            mask_r;
  logic                  take;

  assign in_ready   = !valid_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = valid_r;
  assign push_data  = {x_r, y_r, z_r, mask_r};

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = |in_mask;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      z_r    <= in_pos_z;
      mask_r <= in_mask;
    end
  end

  a_front_has_face: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> mask_r != '0)
    else $error("front holds a cube with no visible face");

endmodule
`default_nettype wire

// ===== rtl/core/vfce_fifo.sv =====
// Small register queue between the front and back stages.
`default_nettype none
module vfce_fifo #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = count_r != CW'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/vfce_back.sv =====
// Back stage: walks the visible faces of a cube and emits six vertices per face.
`default_nettype none
module vfce_back #(
  parameter int COORD_BITS = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire vfce_pkg::tex_bank_t                    tex_i,
  input  wire logic                                   pop_valid,
  output logic                                        pop_ready,
  input  wire logic [3*COORD_BITS+vfce_pkg::NUM_FACES-1:0] pop_data,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [COORD_BITS-1:0]                       out_vert_x,
  output logic [COORD_BITS-1:0]                       out_vert_y,
  output logic [COORD_BITS-1:0]                       out_vert_z,
  output logic                                        out_tex_u,
  output logic                                        out_tex_v,
  output vfce_pkg::face_t                             out_face_id,
  output vfce_pkg::tex_t                              out_texture_id,
  output logic                                        out_last_vertex
);
  import vfce_pkg::*;

  logic                  active_r;
  face_mask_t            mask_r;
  logic [VERT_BITS-1:0]  k_r;
  logic [COORD_BITS-1:0] x_r, y_r, z_r;
  logic                  ov_r;
  logic [COORD_BITS-1:0] vx_r, vy_r, vz_r;
  logic                  u_r, v_r, last_r;
  face_t                 face_r;
  tex_t                  tex_r;

  face_t                 face_sel;
  face_mask_t            rest;
  logic [1:0]            corner;
  logic [2:0]            off;
  logic                  adv, face_end, done, pop;

  always_comb begin
    face_sel = FACE_PX;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        face_sel = FACE_BITS'(i);
      end
    end
  end

  assign rest      = mask_r & ~(NUM_FACES'(1) << face_sel);
  assign corner    = emit_corner(k_r);
  assign off       = corner_offset(face_sel, corner);
  assign adv       = active_r && (!ov_r || out_ready);
  assign face_end  = k_r == LAST_VERT;
  assign done      = adv && face_end && rest == '0;
  assign pop       = pop_valid && (!active_r || done);
  assign pop_ready = !active_r || done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ov_r     <= 1'b0;
      k_r      <= '0;
    end else begin
      if (pop) begin
        active_r <= 1'b1;
        k_r      <= '0;
      end else if (done) begin
        active_r <= 1'b0;
      end else if (adv) begin
        k_r <= face_end ? '0 : k_r + VERT_BITS'(1);
      end
      if (adv) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      {x_r, y_r, z_r, mask_r} <= pop_data;
    end else if (adv && face_end) begin
      mask_r <= rest;
    end
    if (adv) begin
      vx_r   <= x_r + COORD_BITS'(off[2]);
      vy_r   <= y_r + COORD_BITS'(off[1]);
      vz_r   <= z_r + COORD_BITS'(off[0]);
      u_r    <= corner[1];
      v_r    <= corner[0];
      face_r <= face_sel;
      tex_r  <= tex_i[face_sel];
      last_r <= face_end && rest == '0;
    end
  end

  assign out_valid       = ov_r;
  assign out_vert_x      = vx_r;
  assign out_vert_y      = vy_r;
  assign out_vert_z      = vz_r;
  assign out_tex_u       = u_r;
  assign out_tex_v       = v_r;
  assign out_face_id     = face_r;
  assign out_texture_id  = tex_r;
  assign out_last_vertex = last_r;

  a_active_has_face: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> mask_r != '0)
    else $error("active cube with no face left");

  a_last_is_tr: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && last_r |-> u_r && v_r)
    else $error("last vertex is not a top-right corner");

  a_face_end_tr: assert property (@(posedge clk) disable iff (!rst_n)
    adv && face_end |=> ov_r && u_r && v_r)
    else $error("face did not close on a top-right corner");

  a_vert_count: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> k_r <= LAST_VERT)
    else $error("vertex counter out of range");

endmodule
`default_nettype wire

// ===== rtl/core/voxel_face_culling_vertex_emitter_top.sv =====
// Top level of the voxel face culling vertex emitter: config registers, front, queue, back.
//
//  channel | ports                         | moves
//  --------+-------------------------------+---------------------------------
//  in      | in_valid/in_ready, in_pos_*,  | one cube request with 6 flags
//          | in_open_*                     |
//  out     | out_valid/out_ready, out_*    | one vertex per handshake
//  cfg     | cfg_valid/cfg_ready,          | texture id write, index 0..5
//          | cfg_index, cfg_data           |
//
// One vertex per cycle from the back stage's vertex counter while out_ready is high: six
// vertices per visible face, up to 36 per cube; the front drops cubes with no face.
// A request passes the front register, queue, back cube register and output register.
// Synchronous active-low reset empties front, queue and back; texture ids reset to 0.
// Front and back stall independently through the queue; cfg_ready is always high.
`default_nettype none
module voxel_face_culling_vertex_emitter_top #(
  parameter int COORD_BITS  = 8,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [COORD_BITS-1:0]           in_pos_x,
  input  wire logic [COORD_BITS-1:0]           in_pos_y,
  input  wire logic [COORD_BITS-1:0]           in_pos_z,
  input  wire logic                            in_open_pos_x,
  input  wire logic                            in_open_neg_x,
  input  wire logic                            in_open_pos_y,
  input  wire logic                            in_open_neg_y,
  input  wire logic                            in_open_pos_z,
  input  wire logic                            in_open_neg_z,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [COORD_BITS-1:0]                out_vert_x,
  output logic [COORD_BITS-1:0]                out_vert_y,
  output logic [COORD_BITS-1:0]                out_vert_z,
  output logic                                 out_tex_u,
  output logic                                 out_tex_v,
  output vfce_pkg::face_t                      out_face_id,
  output vfce_pkg::tex_t                       out_texture_id,
  output logic                                 out_last_vertex,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [vfce_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire vfce_pkg::tex_t                  cfg_data
);
  import vfce_pkg::*;

  localparam int ITEM_BITS = 3 * COORD_BITS + NUM_FACES;

  tex_bank_t            tex_r;
  face_mask_t           in_mask;
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  logic [ITEM_BITS-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;
  assign in_mask   = {in_open_neg_z, in_open_pos_z, in_open_neg_y,
                      in_open_pos_y, in_open_neg_x, in_open_pos_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_r <= '0;
    end else if (cfg_valid && cfg_index < CFG_IDX_BITS'(NUM_FACES)) begin
      tex_r[cfg_index] <= cfg_data;
    end
  end

  vfce_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pos_x   (in_pos_x),
    .in_pos_y   (in_pos_y),
    .in_pos_z   (in_pos_z),
    .in_mask    (in_mask),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  vfce_fifo #(.WIDTH(ITEM_BITS), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  vfce_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .tex_i           (tex_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_vert_x      (out_vert_x),
    .out_vert_y      (out_vert_y),
    .out_vert_z      (out_vert_z),
    .out_tex_u       (out_tex_u),
    .out_tex_v       (out_tex_v),
    .out_face_id     (out_face_id),
    .out_texture_id  (out_texture_id),
    .out_last_vertex (out_last_vertex)
  );

endmodule
`default_nettype wire

// ===== dv/vfce_vertex_checker.sv =====
// Checker for the vertex emitter: predicts the vertices of each cube request and compares them.
`timescale 1ns / 100ps
module vfce_vertex_checker #(
  parameter int COORD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [COORD_BITS-1:0] in_pos_z,
  input  vfce_pkg::face_mask_t  in_open,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [COORD_BITS-1:0] out_vert_x,
  input  logic [COORD_BITS-1:0] out_vert_y,
  input  logic [COORD_BITS-1:0] out_vert_z,
  input  logic                  out_tex_u,
  input  logic                  out_tex_v,
  input  vfce_pkg::face_t       out_face_id,
  input  vfce_pkg::tex_t        out_texture_id,
  input  logic                  out_last_vertex,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [vfce_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  vfce_pkg::tex_t        cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    verts_seen
);
  import vfce_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic                  u;
    logic                  v;
    face_t                 face;
    tex_t                  tex;
    logic                  last;
  } vertex_t;

  // {x, y, z} offsets, per face, per corner BL, TL, BR, TR
  localparam bit [0:5][0:3][2:0] CORNER_OFS = {
    {3'b101, 3'b111, 3'b100, 3'b110},
    {3'b000, 3'b010, 3'b001, 3'b011},
    {3'b010, 3'b110, 3'b011, 3'b111},
    {3'b100, 3'b000, 3'b101, 3'b001},
    {3'b001, 3'b011, 3'b101, 3'b111},
    {3'b100, 3'b110, 3'b000, 3'b010}
  };

  localparam bit [0:5][1:0] EMIT_SEQ = {
    CORNER_BL, CORNER_TL, CORNER_BR, CORNER_BR, CORNER_TL, CORNER_TR
  };

  vertex_t   expected_verts[$];
  tex_bank_t face_tex;
  int        bad_count;
  int        seen_count;

  function automatic void expand_cube(input logic [COORD_BITS-1:0] px,
                                      input logic [COORD_BITS-1:0] py,
                                      input logic [COORD_BITS-1:0] pz,
                                      input face_mask_t open);
    vertex_t    vtx;
    logic [1:0] c;
    logic [2:0] ofs;
    int         total;
    int         n;
    total = 6 * $countones(open);
    n = 0;
    for (int f = 0; f < NUM_FACES; f++) begin
      if (open[f]) begin
        for (int k = 0; k < 6; k++) begin
          c = EMIT_SEQ[k];
          ofs = CORNER_OFS[f][c];
          vtx.x = px + {{(COORD_BITS-1){1'b0}}, ofs[2]};
          vtx.y = py + {{(COORD_BITS-1){1'b0}}, ofs[1]};
          vtx.z = pz + {{(COORD_BITS-1){1'b0}}, ofs[0]};
          vtx.u = c[1];
          vtx.v = c[0];
          vtx.face = face_t'(f);
          vtx.tex = face_tex[f];
          vtx.last = (n == total - 1);
          expected_verts.insert(expected_verts.size(), vtx);
          n++;
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    vertex_t got;
    vertex_t want;
    if (!rst_n) begin
      expected_verts.delete();
      face_tex = '0;
      bad_count = 0;
      seen_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.x = out_vert_x;
        got.y = out_vert_y;
        got.z = out_vert_z;
        got.u = out_tex_u;
        got.v = out_tex_v;
        got.face = out_face_id;
        got.tex = out_texture_id;
        got.last = out_last_vertex;
        seen_count++;
        if (expected_verts.size() == 0) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: vertex with no request pending: x=%0d y=%0d z=%0d face=%0d",
                     $realtime, got.x, got.y, got.z, got.face);
        end else begin
          want = expected_verts.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.u !== want.u || got.v !== want.v || got.face !== want.face ||
              got.tex !== want.tex || got.last !== want.last) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: vertex mismatch", $realtime);
              $display("  exp x=%0d y=%0d z=%0d uv=%b%b face=%0d tex=%h last=%b",
                       want.x, want.y, want.z, want.u, want.v, want.face, want.tex,
                       want.last);
              $display("  got x=%0d y=%0d z=%0d uv=%b%b face=%0d tex=%h last=%b",
                       got.x, got.y, got.z, got.u, got.v, got.face, got.tex,
                       got.last);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_FACES)
        face_tex[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        expand_cube(in_pos_x, in_pos_y, in_pos_z, in_open);
    end
    mismatches <= bad_count;
    pending <= expected_verts.size();
    verts_seen <= seen_count;
  end

endmodule

// ===== dv/voxel_face_culling_vertex_emitter_top_tb.sv =====
// Testbench top for the voxel face culling vertex emitter: stimulus, output stalls, verdict.
`timescale 1ns / 100ps
module voxel_face_culling_vertex_emitter_top_tb;
  import vfce_pkg::*;

  localparam int HOLD_CYCLES = 400;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_pos_x = '0;
  logic [7:0]              in_pos_y = '0;
  logic [7:0]              in_pos_z = '0;
  face_mask_t              in_open = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [7:0]              out_vert_x;
  logic [7:0]              out_vert_y;
  logic [7:0]              out_vert_z;
  logic                    out_tex_u;
  logic                    out_tex_v;
  face_t                   out_face_id;
  tex_t                    out_texture_id;
  logic                    out_last_vertex;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  tex_t                    cfg_data = '0;

  logic hold_request = 1'b0;
  logic calm = 1'b0;
  int   mismatches;
  int   pending;
  int   verts_seen;
  int   cubes_sent = 0;

  voxel_face_culling_vertex_emitter_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_open_pos_x  (in_open[0]),
    .in_open_neg_x  (in_open[1]),
    .in_open_pos_y  (in_open[2]),
    .in_open_neg_y  (in_open[3]),
    .in_open_pos_z  (in_open[4]),
    .in_open_neg_z  (in_open[5]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_vert_x     (out_vert_x),
    .out_vert_y     (out_vert_y),
    .out_vert_z     (out_vert_z),
    .out_tex_u      (out_tex_u),
    .out_tex_v      (out_tex_v),
    .out_face_id    (out_face_id),
    .out_texture_id (out_texture_id),
    .out_last_vertex(out_last_vertex),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  vfce_vertex_checker #(.COORD_BITS(8)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_open        (in_open),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_vert_x     (out_vert_x),
    .out_vert_y     (out_vert_y),
    .out_vert_z     (out_vert_z),
    .out_tex_u      (out_tex_u),
    .out_tex_v      (out_tex_v),
    .out_face_id    (out_face_id),
    .out_texture_id (out_texture_id),
    .out_last_vertex(out_last_vertex),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .pending        (pending),
    .verts_seen     (verts_seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic send_cube(input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
                           input face_mask_t open);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_open <= open;
    do @(posedge clk); while (!in_ready);
    cubes_sent++;
  endtask

  task automatic write_tex(input logic [CFG_IDX_BITS-1:0] idx, input tex_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // out-of-range indexes go along with every bank load; they must be ignored
  task automatic load_bank(input tex_bank_t bank);
    for (int i = 0; i < NUM_FACES; i++)
      write_tex(CFG_IDX_BITS'(i), bank[i]);
    write_tex(CFG_IDX_BITS'(6), tex_t'($urandom));
    write_tex(CFG_IDX_BITS'(7), tex_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // wait until no vertex is pending, with input held idle, then idle before the next step
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_cubes(input int n);
    face_mask_t m;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 12) m = '0;
      else if (r < 22) m = '1;
      else m = face_mask_t'($urandom);
      send_cube(8'($urandom), 8'($urandom), 8'($urandom), m);
    end
  endtask

  function automatic tex_bank_t random_bank();
    tex_bank_t b;
    for (int i = 0; i < NUM_FACES; i++)
      b[i] = tex_t'($urandom);
    return b;
  endfunction

  initial begin
    tex_bank_t bank;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset texture ids
    send_cube(8'd0, 8'd0, 8'd0, '1);
    send_cube(8'd255, 8'd255, 8'd255, '1);
    send_cube(8'd17, 8'd99, 8'd201, '0);
    settle();

    bank[0] = 16'hFFFF;
    bank[1] = 16'h0000;
    bank[2] = 16'h8000;
    bank[3] = 16'h7FFF;
    bank[4] = 16'h5555;
    bank[5] = 16'hAAAA;
    load_bank(bank);

    // each face alone, at the edges of the coordinate range
    for (int f = 0; f < NUM_FACES; f++)
      send_cube(f[0] ? 8'd255 : 8'd0, f[1] ? 8'd255 : 8'd0, f[2] ? 8'd0 : 8'd255,
                face_mask_t'(1 << f));
    send_cube(8'd0, 8'd0, 8'd0, '0);
    send_cube(8'd255, 8'd0, 8'd255, '1);
    send_cube(8'd0, 8'd255, 8'd0, '1);
    send_cube(8'h55, 8'hAA, 8'h7F, 6'b101010);
    send_cube(8'hAA, 8'h55, 8'h80, 6'b010101);
    send_cube(8'd254, 8'd254, 8'd254, '0);
    send_cube(8'd254, 8'd254, 8'd254, 6'b110000);
    settle();

    load_bank(random_bank());
    random_cubes(24);
    settle();

    bank = {NUM_FACES{16'hFFFF}};
    load_bank(bank);
    hold_request <= 1'b1;
    random_cubes(24);
    settle();

    load_bank('0);
    calm <= 1'b1;
    random_cubes(24);
    settle();

    calm <= 1'b0;
    load_bank(random_bank());
    random_cubes(24);
    settle();
    repeat (20) @(posedge clk);

    $display("Covered %0d cube requests and %0d vertices over six texture settings,",
             cubes_sent, verts_seen);
    $display("with single faces, coordinate wrap, empty cubes and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
